@@ rtl/mono_column_to_rgb565_spi_writer_macros.svh @@
// Assertion macros for the glyph column writer checker
`ifndef MONO_COLUMN_TO_RGB565_SPI_WRITER_MACROS_SVH
`define MONO_COLUMN_TO_RGB565_SPI_WRITER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define MCRSW_ASSERT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define MCRSW_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mcrsw_pkg.sv @@
// Shared types and constants of the glyph column writer
package mcrsw_pkg;

    localparam logic [7:0]  CMD_COLUMN_ADDR = 8'h2A;
    localparam logic [7:0]  CMD_ROW_ADDR    = 8'h2B;
    localparam logic [7:0]  CMD_RAM_WRITE   = 8'h2C;
    localparam logic [15:0] BG_RESET        = 16'd21455;
    localparam int          HDR_LEN         = 11;

    localparam logic [4:0] SLOT_COL_CMD = 5'd0;
    localparam logic [4:0] SLOT_COL_SH  = 5'd1;
    localparam logic [4:0] SLOT_COL_SL  = 5'd2;
    localparam logic [4:0] SLOT_COL_EH  = 5'd3;
    localparam logic [4:0] SLOT_COL_EL  = 5'd4;
    localparam logic [4:0] SLOT_ROW_CMD = 5'd5;
    localparam logic [4:0] SLOT_ROW_SH  = 5'd6;
    localparam logic [4:0] SLOT_ROW_SL  = 5'd7;
    localparam logic [4:0] SLOT_ROW_EH  = 5'd8;
    localparam logic [4:0] SLOT_ROW_EL  = 5'd9;
    localparam logic [4:0] SLOT_RAM_CMD = 5'd10;
    localparam logic [4:0] SLOT_PIX0    = 5'd11;

    typedef struct packed {
        logic        err;
        logic [7:0]  bits;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  end_row;
        logic [3:0]  height;
        logic [15:0] fg;
    } pend_t;

endpackage

@@ rtl/mono_column_to_rgb565_spi_writer.sv @@
// Glyph column writer: one mono column in, display address/pixel byte stream out
// An item yields 11 + 2*run_height output bytes (27 at full height), a single
// zero byte for an out-of-window item, all through the single output byte register.
// One further item is held in an input buffer while the previous one streams,
// so back-to-back columns leave no gap on the output. Pixel colours are picked
// by MAX_RUN parallel lanes when an item enters the serializer; the background
// colour register is sampled then.
module mono_column_to_rgb565_spi_writer
    import mcrsw_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = 160,
    parameter int DISPLAY_HEIGHT = 128,
    parameter int MAX_RUN        = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // column_bits, column_x, top_y, run_height, foreground_colour
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // spi_byte
    output logic [1:0]  m_tuser,  // is_data, window_error
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic        pend_valid_reg;
    pend_t       pend_reg;
    logic [15:0] bg_reg;

    logic                  take;
    logic                  in_xfer;
    logic [7:0]            in_x;
    logic [7:0]            in_y;
    logic [3:0]            in_h;
    logic [8:0]            in_end;
    logic                  in_err;
    logic [MAX_RUN*16-1:0] pixels;

    assign cfg_ready = 1'b1;
    assign s_tready  = !pend_valid_reg || take;
    assign in_xfer   = s_tvalid && s_tready;

    assign in_x   = s_tdata[15:8];
    assign in_y   = s_tdata[23:16];
    assign in_h   = s_tdata[27:24];
    assign in_end = {1'b0, in_y} + {5'd0, in_h} - 9'd1;
    assign in_err = (in_h == 4'd0) || (in_h > 4'(MAX_RUN))
                 || ({1'b0, in_x} >= 9'(DISPLAY_WIDTH))
                 || ({1'b0, in_y} >= 9'(DISPLAY_HEIGHT))
                 || (in_end >= 9'(DISPLAY_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            bg_reg         <= BG_RESET;
        end
        else
        begin
            if (in_xfer)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (take)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                bg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pend_reg.err     <= in_err;
            pend_reg.bits    <= s_tdata[7:0];
            pend_reg.x       <= in_x;
            pend_reg.y       <= in_y;
            pend_reg.end_row <= in_end[7:0];
            pend_reg.height  <= in_h;
            pend_reg.fg      <= s_tdata[43:28];
        end
    end

    for (genvar g = 0; g < MAX_RUN; g++)
    begin : g_lane
        mcrsw_lane u_lane (
            .clk     (clk),
            .load    (take),
            .pix_bit (pend_reg.bits[g]),
            .fg      (pend_reg.fg),
            .bg      (bg_reg),
            .pixel   (pixels[g*16 +: 16])
        );
    end

    mcrsw_ser #(
        .MAX_RUN (MAX_RUN)
    ) u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .pend_valid (pend_valid_reg),
        .pend       (pend_reg),
        .pixels     (pixels),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

@@ rtl/mcrsw_lane.sv @@
// One pixel lane: picks and holds the colour of one pixel of the column
module mcrsw_lane
    import mcrsw_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic        pix_bit,
    input  logic [15:0] fg,
    input  logic [15:0] bg,
    output logic [15:0] pixel
);

    logic [15:0] pixel_reg;
    logic [15:0] pixel_next;

    always_comb
    begin
        pixel_next = pixel_reg;
        if (load)
        begin
            pixel_next = pix_bit ? fg : bg;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg <= pixel_next;
    end

    assign pixel = pixel_reg;

endmodule

@@ rtl/mcrsw_ser.sv @@
// Byte serializer: merges header fields and lane pixels into the output stream
module mcrsw_ser
    import mcrsw_pkg::*;
#(
    parameter int MAX_RUN = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pend_valid,
    input  pend_t                 pend,
    input  logic [MAX_RUN*16-1:0] pixels,
    output logic                  take,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,
    output logic [1:0]            m_tuser,
    output logic                  m_tlast
);

    localparam int IDX_W  = $clog2(HDR_LEN + 2 * MAX_RUN);
    localparam int LANE_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] last_idx_reg;
    logic             err_reg;
    logic [7:0]       x_reg;
    logic [7:0]       y_reg;
    logic [7:0]       end_reg;
    logic             m_valid_reg;
    logic [7:0]       m_data_reg;
    logic [1:0]       m_user_reg;
    logic             m_last_reg;

    logic              advance;
    logic              at_last;
    logic [4:0]        slot;
    logic [4:0]        pix_off;
    logic [LANE_W-1:0] lane;
    logic [15:0]       pix_sel;
    logic [7:0]        byte_val;
    logic              is_data;

    assign advance = !m_valid_reg || m_tready;
    assign at_last = busy_reg && (idx_reg == last_idx_reg);
    assign take    = pend_valid && (!busy_reg || (advance && at_last));

    assign slot    = 5'(idx_reg);
    assign pix_off = slot - SLOT_PIX0;
    assign lane    = pix_off[LANE_W:1];
    assign pix_sel = pixels[lane*16 +: 16];

    always_comb
    begin
        byte_val = 8'd0;
        is_data  = 1'b1;
        case (slot)
            SLOT_COL_CMD:
            begin
                byte_val = CMD_COLUMN_ADDR;
                is_data  = 1'b0;
            end
            SLOT_COL_SH: byte_val = 8'd0;
            SLOT_COL_SL: byte_val = x_reg;
            SLOT_COL_EH: byte_val = 8'd0;
            SLOT_COL_EL: byte_val = x_reg;
            SLOT_ROW_CMD:
            begin
                byte_val = CMD_ROW_ADDR;
                is_data  = 1'b0;
            end
            SLOT_ROW_SH: byte_val = 8'd0;
            SLOT_ROW_SL: byte_val = y_reg;
            SLOT_ROW_EH: byte_val = 8'd0;
            SLOT_ROW_EL: byte_val = end_reg;
            SLOT_RAM_CMD:
            begin
                byte_val = CMD_RAM_WRITE;
                is_data  = 1'b0;
            end
            default: byte_val = pix_off[0] ? pix_sel[15:8] : pix_sel[7:0];
        endcase
        if (err_reg)
        begin
            byte_val = 8'd0;
            is_data  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (advance && busy_reg)
            begin
                busy_reg <= !at_last;
                idx_reg  <= idx_reg + 1'b1;
            end
            if (advance)
            begin
                m_valid_reg <= busy_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            err_reg      <= pend.err;
            x_reg        <= pend.x;
            y_reg        <= pend.y;
            end_reg      <= pend.end_row;
            last_idx_reg <= pend.err ? '0
                          : IDX_W'(HDR_LEN - 1) + IDX_W'({pend.height, 1'b0});
        end
        if (advance && busy_reg)
        begin
            m_data_reg <= byte_val;
            m_user_reg <= {err_reg, is_data};
            m_last_reg <= at_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ rtl/mcrsw_checker.sv @@
// Port checker for the glyph column writer and its bind
`include "mono_column_to_rgb565_spi_writer_macros.svh"

module mcrsw_checker
    import mcrsw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    `MCRSW_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "stalled output transfer changed")

    `MCRSW_ASSERT(a_err_single, m_tvalid && m_tuser[1],
        m_tlast && !m_tuser[0] && (m_tdata == 8'd0),
        "error result is not a single zero command byte")

    `MCRSW_ASSERT(a_cmd_code, m_tvalid && !m_tuser[0] && !m_tuser[1],
        (m_tdata == CMD_COLUMN_ADDR) || (m_tdata == CMD_ROW_ADDR)
        || (m_tdata == CMD_RAM_WRITE),
        "command byte with unknown code")

    `MCRSW_ASSERT(a_last_is_data, m_tvalid && m_tlast && !m_tuser[1],
        m_tuser[0],
        "normal item does not end on a pixel byte")

endmodule

bind mono_column_to_rgb565_spi_writer mcrsw_checker u_mcrsw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

@@ test/testbench.sv @@
// Testbench for the glyph column writer: predicts and checks the address/pixel byte stream
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mcrsw_pkg::*;

    localparam int DISP_W       = 160;
    localparam int DISP_H       = 128;
    localparam int RUN_MAX      = 8;
    localparam int SETTLE_WAIT  = 60;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0]  bits;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [3:0]  height;
        logic [15:0] fg;
    } column_t;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       is_data;
        logic       window_error;
        logic       last_byte;
    } spi_word_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    spi_word_t   expected_bytes[$];
    logic [15:0] background;
    int          fail_count;
    int          cycle_count;
    int          burst_left;
    bit          sender_gaps_on;
    int          ready_mode;
    int          mode_left;
    int          pattern_pos;

    mono_column_to_rgb565_spi_writer #(
        .DISPLAY_WIDTH  (DISP_W),
        .DISPLAY_HEIGHT (DISP_H),
        .MAX_RUN        (RUN_MAX)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // column_bits, column_x, top_y, run_height, foreground_colour
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // spi_byte
        .m_tuser   (m_tuser),   // is_data, window_error
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(20, 300);
        end
        else
            mode_left <= mode_left - 1;
        pattern_pos <= pattern_pos + 1;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2: m_tready <= (pattern_pos % 4) == 0;
            default: m_tready <= (pattern_pos % 7) < 5;
        endcase
    end

    always @(posedge clk)
    begin : check_bytes
        spi_word_t got;
        spi_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata, m_tuser[0], m_tuser[1], m_tlast};
            if (expected_bytes.size() == 0)
            begin
                if (fail_count < REPORT_LIMIT)
                    $display("unexpected transfer: byte %h data %b err %b last %b",
                             got.spi_byte, got.is_data, got.window_error, got.last_byte);
                fail_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (got.spi_byte !== want.spi_byte || got.is_data !== want.is_data ||
                    got.window_error !== want.window_error ||
                    got.last_byte !== want.last_byte)
                begin
                    if (fail_count < REPORT_LIMIT)
                        $display({"mismatch: expected byte %h data %b err %b last %b, ",
                                  "got byte %h data %b err %b last %b"},
                                 want.spi_byte, want.is_data, want.window_error,
                                 want.last_byte, got.spi_byte, got.is_data,
                                 got.window_error, got.last_byte);
                    fail_count++;
                end
            end
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic dc);
        spi_word_t w;
        w.spi_byte     = b;
        w.is_data      = dc;
        w.window_error = 1'b0;
        w.last_byte    = 1'b0;
        expected_bytes.push_back(w);
    endtask

    task automatic draw_column_bytes(input column_t c);
        spi_word_t   w;
        int          end_row;
        logic [15:0] pix;
        if (c.height == 0 || c.height > RUN_MAX || c.x >= DISP_W || c.y >= DISP_H ||
            int'(c.y) + int'(c.height) - 1 >= DISP_H)
        begin
            w = '{spi_byte: 8'h00, is_data: 1'b0, window_error: 1'b1, last_byte: 1'b1};
            expected_bytes.push_back(w);
            return;
        end
        end_row = int'(c.y) + int'(c.height) - 1;
        push_byte(CMD_COLUMN_ADDR, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(c.x, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(c.x, 1'b1);
        push_byte(CMD_ROW_ADDR, 1'b0);
        push_byte(8'h00, 1'b1);
        push_byte(c.y, 1'b1);
        push_byte(8'h00, 1'b1);
        push_byte(end_row[7:0], 1'b1);
        push_byte(CMD_RAM_WRITE, 1'b0);
        for (int i = 0; i < c.height; i++)
        begin
            pix = c.bits[i] ? c.fg : background;
            push_byte(pix[7:0], 1'b1);
            push_byte(pix[15:8], 1'b1);
        end
        expected_bytes[expected_bytes.size() - 1].last_byte = 1'b1;
    endtask

    task automatic send_column(input column_t c);
        int gap;
        if (burst_left == 0)
        begin
            gap = 0;
            if (sender_gaps_on)
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, c.fg, c.height, c.y, c.x, c.bits};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        draw_column_bytes(c);
    endtask

    task automatic drain_columns();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic load_background(input logic [15:0] colour);
        drain_columns();
        cfg_valid <= 1'b1;
        cfg_data  <= colour;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        background = colour;
    endtask

    function automatic column_t make_column(input logic [7:0] bits, input logic [7:0] x,
                                            input logic [7:0] y, input logic [3:0] h,
                                            input logic [15:0] fg);
        column_t c;
        c.bits   = bits;
        c.x      = x;
        c.y      = y;
        c.height = h;
        c.fg     = fg;
        return c;
    endfunction

    function automatic column_t random_column();
        column_t c;
        int      kind;
        kind     = $urandom_range(0, 99);
        c.bits   = 8'($urandom);
        c.fg     = 16'($urandom);
        c.height = 4'($urandom_range(1, RUN_MAX));
        c.x      = 8'($urandom_range(0, DISP_W - 1));
        c.y      = 8'($urandom_range(0, DISP_H - int'(c.height)));
        if (kind >= 97)
        begin
            c.height = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(RUN_MAX + 1, 15));
            c.y      = 8'($urandom);
            c.x      = 8'($urandom);
        end
        else if (kind >= 94)
        begin
            c.height = 4'($urandom_range(2, RUN_MAX));
            c.y      = 8'($urandom_range(DISP_H + 1 - int'(c.height), DISP_H - 1));
        end
        else if (kind >= 91)
            c.y = 8'($urandom_range(DISP_H, 255));
        else if (kind >= 88)
            c.x = 8'($urandom_range(DISP_W, 255));
        return c;
    endfunction

    task automatic test_directed_columns();
        sender_gaps_on = 1'b0;
        send_column(make_column(8'h00, 8'd0, 8'd0, 4'd1, 16'h0000));
        send_column(make_column(8'hFF, 8'd159, 8'd120, 4'd8, 16'hFFFF));
        send_column(make_column(8'hAA, 8'd80, 8'd64, 4'd8, 16'h1234));
        send_column(make_column(8'h55, 8'd1, 8'd127, 4'd1, 16'hF800));
        send_column(make_column(8'hFF, 8'd255, 8'd255, 4'd8, 16'h07E0));
        send_column(make_column(8'h01, 8'd160, 8'd10, 4'd4, 16'h001F));
        send_column(make_column(8'h80, 8'd10, 8'd128, 4'd4, 16'hABCD));
        send_column(make_column(8'h0F, 8'd10, 8'd121, 4'd8, 16'h5A5A));
        send_column(make_column(8'hF0, 8'd10, 8'd120, 4'd8, 16'hA5A5));
        send_column(make_column(8'h33, 8'd20, 8'd20, 4'd0, 16'h0F0F));
        send_column(make_column(8'hCC, 8'd20, 8'd20, 4'd9, 16'hF0F0));
        send_column(make_column(8'hFF, 8'd20, 8'd20, 4'd15, 16'hFFFF));
        send_column(make_column(8'h00, 8'd158, 8'd0, 4'd8, 16'hFFFF));
        send_column(make_column(8'hFF, 8'd127, 8'd100, 4'd5, 16'h0000));
        send_column(make_column(8'h7E, 8'd64, 8'd126, 4'd3, 16'h8001));
        send_column(make_column(8'h81, 8'd32, 8'd64, 4'd2, 16'h7FFE));
    endtask

    task automatic test_background_extremes();
        load_background(16'h0000);
        send_column(make_column(8'h5A, 8'd40, 8'd40, 4'd8, 16'hFFFF));
        send_column(make_column(8'h00, 8'd159, 8'd127, 4'd1, 16'h1234));
        load_background(16'hFFFF);
        send_column(make_column(8'hA5, 8'd40, 8'd40, 4'd8, 16'h0000));
        send_column(make_column(8'h00, 8'd0, 8'd0, 4'd8, 16'h0000));
    endtask

    task automatic test_random_columns(input logic [15:0] colour, input int count,
                                       input bit gaps);
        load_background(colour);
        sender_gaps_on = gaps;
        repeat (count)
            send_column(random_column());
    endtask

    initial
    begin
        background     = BG_RESET;
        fail_count     = 0;
        cycle_count    = 0;
        burst_left     = 0;
        sender_gaps_on = 1'b0;
        ready_mode     = 0;
        mode_left      = 0;
        pattern_pos    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_columns();
        test_background_extremes();
        test_random_columns(16'($urandom), 110, 1'b1);
        test_random_columns(16'h0000, 100, 1'b0);
        test_random_columns(16'hFFFF, 100, 1'b1);
        test_random_columns(16'($urandom), 100, 1'b1);

        drain_columns();
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/mcrsw_pkg.sv
rtl/mcrsw_lane.sv
rtl/mcrsw_ser.sv
rtl/mono_column_to_rgb565_spi_writer.sv
rtl/mcrsw_checker.sv
test/testbench.sv
